>>> hdl/msfd_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte update for the Modbus sensor decoder.
// Used by the front end, queue, back end, top level and testbench; depends on nothing.
package msfd_pkg;

    localparam logic [7:0]  ADDR_ANGLE    = 8'h01;
    localparam logic [7:0]  ADDR_MAX      = 8'h05;
    localparam logic [3:0]  ANGLE_CRC_LO  = 4'd11;
    localparam logic [3:0]  ADC_CRC_LO    = 4'd9;
    localparam logic [3:0]  PAYLOAD_FIRST = 4'd3;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    localparam logic signed [31:0] GAIN_RESET   = 32'sd15626;
    localparam logic signed [31:0] OFFSET_RESET = 32'sd24556339;

    localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
    localparam logic signed [49:0] SAT_MIN = -SAT_MAX - 50'sd1;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        REG_GAIN_ONE   = 2'd0,
        REG_OFFSET_ONE = 2'd1,
        REG_GAIN_TWO   = 2'd2,
        REG_OFFSET_TWO = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]  slave_address;
        logic        crc_ok;
        logic        is_angle;
        logic [31:0] angle_x_bits;
        logic [31:0] angle_y_bits;
        logic [23:0] raw_one;
        logic [23:0] raw_two;
    } t_frame;

    typedef struct packed {
        logic signed [31:0] gain_one;
        logic signed [31:0] offset_one;
        logic signed [31:0] gain_two;
        logic signed [31:0] offset_two;
    } t_cal;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/msfd_if.sv
// Valid/ready channel interfaces for received bytes and decoded frame results.
// Depends on nothing.
interface msfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface msfd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         slave_address;
    logic               crc_ok;
    logic               is_angle;
    logic [31:0]        angle_x_bits;
    logic [31:0]        angle_y_bits;
    logic signed [31:0] channel_one_value;
    logic signed [31:0] channel_two_value;

    modport source (output valid, output slave_address, output crc_ok, output is_angle,
                    output angle_x_bits, output angle_y_bits, output channel_one_value,
                    output channel_two_value, input ready);
    modport sink   (input valid, input slave_address, input crc_ok, input is_angle,
                    input angle_x_bits, input angle_y_bits, input channel_one_value,
                    input channel_two_value, output ready);
endinterface

>>> hdl/msfd_front.sv
// Byte front end: frame tracking, running CRC, payload capture and kept angles.
// Depends on msfd_pkg and msfd_in_if; pushes one frame record per completed frame.
module msfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    msfd_in_if.sink           i_rx,
    input  logic              i_full,
    output logic              o_push,
    output msfd_pkg::t_frame  o_frame
);

    logic        r_active;
    logic [3:0]  r_count;
    logic [15:0] r_crc;
    logic [7:0]  r_addr;
    logic [63:0] r_shift;
    logic [7:0]  r_crc_lo;
    logic [31:0] r_angle_x;
    logic [31:0] r_angle_y;

    logic        w_acc;
    logic        w_angle;
    logic [3:0]  w_crc_lo_pos;
    logic        w_ok;
    logic        w_addr_valid;
    logic        w_take_angle;
    logic        w_take_adc;

    assign i_rx.ready = !i_full;
    assign w_acc      = i_rx.valid && i_rx.ready;

    always_comb begin
        w_angle      = (r_addr == msfd_pkg::ADDR_ANGLE);
        w_crc_lo_pos = w_angle ? msfd_pkg::ANGLE_CRC_LO : msfd_pkg::ADC_CRC_LO;
        w_ok         = (r_crc_lo == r_crc[7:0]) && (i_rx.rx_byte == r_crc[15:8]);
        w_addr_valid = (i_rx.rx_byte != 8'h00) && (i_rx.rx_byte <= msfd_pkg::ADDR_MAX);
        w_take_angle = w_angle && w_ok;
        w_take_adc   = !w_angle && w_ok;
        o_push       = w_acc && !i_rx.frame_start && r_active &&
                       (r_count == (w_crc_lo_pos + 4'd1));

        o_frame.slave_address = r_addr[2:0];
        o_frame.crc_ok        = w_ok;
        o_frame.is_angle      = w_angle;
        o_frame.angle_x_bits  = w_take_angle ? r_shift[63:32] : r_angle_x;
        o_frame.angle_y_bits  = w_take_angle ? r_shift[31:0] : r_angle_y;
        o_frame.raw_one       = w_take_adc ? r_shift[47:24] : 24'h000000;
        o_frame.raw_two       = w_take_adc ? r_shift[23:0] : 24'h000000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_count   <= 4'd0;
            r_crc     <= msfd_pkg::CRC_INIT;
            r_addr    <= 8'h00;
            r_shift   <= 64'h0;
            r_crc_lo  <= 8'h00;
            r_angle_x <= 32'h0;
            r_angle_y <= 32'h0;
        end else if (w_acc) begin
            if (i_rx.frame_start) begin
                r_addr   <= i_rx.rx_byte;
                r_active <= w_addr_valid;
                r_shift  <= 64'h0;
                r_crc_lo <= 8'h00;
                if (w_addr_valid) begin
                    r_crc   <= msfd_pkg::crc_update(msfd_pkg::CRC_INIT, i_rx.rx_byte);
                    r_count <= 4'd1;
                end else begin
                    r_crc   <= msfd_pkg::CRC_INIT;
                    r_count <= 4'd0;
                end
            end else if (r_active) begin
                if (r_count < w_crc_lo_pos) begin
                    r_crc <= msfd_pkg::crc_update(r_crc, i_rx.rx_byte);
                    if (r_count >= msfd_pkg::PAYLOAD_FIRST) begin
                        r_shift <= {r_shift[55:0], i_rx.rx_byte};
                    end
                    r_count <= r_count + 4'd1;
                end else if (r_count == w_crc_lo_pos) begin
                    r_crc_lo <= i_rx.rx_byte;
                    r_count  <= r_count + 4'd1;
                end else begin
                    if (w_take_angle) begin
                        r_angle_x <= r_shift[63:32];
                        r_angle_y <= r_shift[31:0];
                    end
                    r_active <= 1'b0;
                    r_count  <= 4'd0;
                end
            end
        end
    end

endmodule

>>> hdl/msfd_fifo.sv
// Short queue of frame records between the byte front end and the calibration back end.
// Depends on msfd_pkg.
module msfd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  msfd_pkg::t_frame  i_frame,
    input  logic              i_pop,
    output msfd_pkg::t_frame  o_frame,
    output logic              o_full,
    output logic              o_empty
);

    // The head of the queue always sits in the first slot; a pop shifts the slots down.
    msfd_pkg::t_frame              r_slot [msfd_pkg::QUEUE_DEPTH];
    msfd_pkg::t_frame              n_slot [msfd_pkg::QUEUE_DEPTH];
    logic [msfd_pkg::QUEUE_AW:0]   r_fill;
    logic [msfd_pkg::QUEUE_AW:0]   w_wr_idx;

    assign o_full   = (r_fill == (msfd_pkg::QUEUE_AW + 1)'(msfd_pkg::QUEUE_DEPTH));
    assign o_empty  = (r_fill == '0);
    assign o_frame  = r_slot[0];
    assign w_wr_idx = i_pop ? (r_fill - 1'b1) : r_fill;

    always_comb begin
        n_slot = r_slot;
        if (i_pop) begin
            for (int i = 0; i + 1 < msfd_pkg::QUEUE_DEPTH; i++) begin
                n_slot[i] = r_slot[i + 1];
            end
        end
        if (i_push) begin
            n_slot[w_wr_idx[msfd_pkg::QUEUE_AW-1:0]] = i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

>>> hdl/msfd_back.sv
// Calibration back end: multiply stage, then round, offset and saturate into the result register.
// Depends on msfd_pkg and msfd_out_if; pops frame records from msfd_fifo.
module msfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msfd_pkg::t_cal    i_cal,
    input  logic              i_empty,
    input  msfd_pkg::t_frame  i_frame,
    output logic              o_pop,
    msfd_out_if.source        o_res
);

    function automatic logic signed [31:0] round_sat(input logic signed [55:0] p,
                                                     input logic signed [31:0] off);
        logic signed [57:0] t;
        logic signed [49:0] q;
        t = 58'(p) + (58'(off) <<< 8) + 58'sd128;
        q = 50'(t >>> 8);
        if (q > msfd_pkg::SAT_MAX) begin
            return 32'sh7FFFFFFF;
        end else if (q < msfd_pkg::SAT_MIN) begin
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    logic                      r_s1_valid;
    msfd_pkg::t_frame          r_s1_frame;
    logic signed [55:0]        r_prod_one;
    logic signed [55:0]        r_prod_two;
    logic signed [31:0]        r_off_one;
    logic signed [31:0]        r_off_two;
    logic                      r_out_valid;

    logic signed [31:0] w_gain_one;
    logic signed [31:0] w_gain_two;
    logic signed [23:0] w_raw_one;
    logic signed [23:0] w_raw_two;
    logic               w_out_free;
    logic               w_s1_adv;

    assign w_gain_one = i_cal.gain_one;
    assign w_gain_two = i_cal.gain_two;
    assign w_raw_one  = i_frame.raw_one;
    assign w_raw_two  = i_frame.raw_two;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign o_pop      = !i_empty && (!r_s1_valid || w_out_free);
    assign o_res.valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_frame <= i_frame;
            r_prod_one <= w_gain_one * w_raw_one;
            r_prod_two <= w_gain_two * w_raw_two;
            r_off_one  <= i_cal.offset_one;
            r_off_two  <= i_cal.offset_two;
        end
        if (w_s1_adv) begin
            o_res.slave_address <= r_s1_frame.slave_address;
            o_res.crc_ok        <= r_s1_frame.crc_ok;
            o_res.is_angle      <= r_s1_frame.is_angle;
            o_res.angle_x_bits  <= r_s1_frame.angle_x_bits;
            o_res.angle_y_bits  <= r_s1_frame.angle_y_bits;
            o_res.channel_one_value <= r_s1_frame.is_angle ? 32'sd0 :
                                       round_sat(r_prod_one, r_off_one);
            o_res.channel_two_value <= r_s1_frame.is_angle ? 32'sd0 :
                                       round_sat(r_prod_two, r_off_two);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/modbus_sensor_frame_decoder.sv
// Modbus RTU sensor reply decoder: accepts one byte per cycle, with no stall while the queue
// has room. After the final CRC byte is accepted, a result passes through the queue, the
// multiply stage and the round/saturate output register.
// Results can issue one per cycle while o_res.ready is high; the two-entry queue absorbs output stalls.
// Synchronous active-low reset clears frame tracking, kept angles, the queue and the
// calibration registers to their defaults.
module modbus_sensor_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msfd_in_if.sink     i_rx,
    msfd_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    msfd_pkg::t_cal   r_cal;
    msfd_pkg::t_frame w_push_frame;
    msfd_pkg::t_frame w_pop_frame;
    msfd_pkg::t_reg_idx w_idx;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;

    assign pready = 1'b1;
    assign w_idx  = msfd_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.gain_one   <= msfd_pkg::GAIN_RESET;
            r_cal.offset_one <= msfd_pkg::OFFSET_RESET;
            r_cal.gain_two   <= msfd_pkg::GAIN_RESET;
            r_cal.offset_two <= msfd_pkg::OFFSET_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                msfd_pkg::REG_GAIN_ONE:   r_cal.gain_one   <= pwdata;
                msfd_pkg::REG_OFFSET_ONE: r_cal.offset_one <= pwdata;
                msfd_pkg::REG_GAIN_TWO:   r_cal.gain_two   <= pwdata;
                msfd_pkg::REG_OFFSET_TWO: r_cal.offset_two <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            msfd_pkg::REG_GAIN_ONE:   prdata = r_cal.gain_one;
            msfd_pkg::REG_OFFSET_ONE: prdata = r_cal.offset_one;
            msfd_pkg::REG_GAIN_TWO:   prdata = r_cal.gain_two;
            msfd_pkg::REG_OFFSET_TWO: prdata = r_cal.offset_two;
            default:                  prdata = 32'h0;
        endcase
    end

    msfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_frame (w_push_frame)
    );

    msfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_push_frame),
        .i_pop   (w_pop),
        .o_frame (w_pop_frame),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    msfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (r_cal),
        .i_empty (w_empty),
        .i_frame (w_pop_frame),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

>>> hdl/msfd_checker.sv
// Port-level checks on the result channel of the sensor frame decoder, with its bind.
// Depends only on the top level's ports.
module msfd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [2:0]         i_slave_address,
    input logic               i_crc_ok,
    input logic               i_is_angle,
    input logic [31:0]        i_angle_x_bits,
    input logic [31:0]        i_angle_y_bits,
    input logic signed [31:0] i_channel_one_value,
    input logic signed [31:0] i_channel_two_value
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_slave_address) && $stable(i_crc_ok) &&
        $stable(i_angle_x_bits) && $stable(i_channel_one_value))
        else $error("result changed while stalled");

    a_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_angle |-> (i_slave_address == 3'd1) &&
        (i_channel_one_value == 32'sd0) && (i_channel_two_value == 32'sd0))
        else $error("angle result with wrong address or nonzero channels");

    a_adc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_is_angle |-> (i_slave_address >= 3'd2) && (i_slave_address <= 3'd5))
        else $error("sample result with address outside two to five");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_angle_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_is_angle ##1 i_valid && !i_is_angle |->
        (i_angle_x_bits == $past(i_angle_x_bits)) && (i_angle_y_bits == $past(i_angle_y_bits)))
        else $error("kept angles changed between sample results");

endmodule

bind modbus_sensor_frame_decoder msfd_checker u_msfd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (o_res.valid),
    .i_ready             (o_res.ready),
    .i_slave_address     (o_res.slave_address),
    .i_crc_ok            (o_res.crc_ok),
    .i_is_angle          (o_res.is_angle),
    .i_angle_x_bits      (o_res.angle_x_bits),
    .i_angle_y_bits      (o_res.angle_y_bits),
    .i_channel_one_value (o_res.channel_one_value),
    .i_channel_two_value (o_res.channel_two_value)
);

>>> verif/msfd_tb_pkg.sv
// Expected-result model and scoreboard for the Modbus sensor frame decoder testbench.
// Depends on msfd_pkg for the register indexes, frame constants and calibration defaults.
package msfd_tb_pkg;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        logic [2:0]  slave_address;
        logic        crc_ok;
        logic        is_angle;
        logic [31:0] angle_x_bits;
        logic [31:0] angle_y_bits;
        logic [31:0] channel_one_value;
        logic [31:0] channel_two_value;
    } t_decoded;

    function automatic logic [15:0] modbus_crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ msfd_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    class msfd_scoreboard;
        logic signed [31:0] gain_a, offset_a, gain_b, offset_b;
        logic [3:0]         byte_pos;
        bit                 in_frame;
        logic [15:0]        crc_run;
        logic [7:0]         frame_addr;
        logic [63:0]        payload;
        logic [7:0]         crc_lo;
        logic [31:0]        kept_x, kept_y;
        t_decoded           pending[$];
        int unsigned        faults;

        function new();
            gain_a     = msfd_pkg::GAIN_RESET;
            offset_a   = msfd_pkg::OFFSET_RESET;
            gain_b     = msfd_pkg::GAIN_RESET;
            offset_b   = msfd_pkg::OFFSET_RESET;
            byte_pos   = '0;
            in_frame   = 1'b0;
            crc_run    = msfd_pkg::CRC_INIT;
            frame_addr = '0;
            payload    = '0;
            crc_lo     = '0;
            kept_x     = '0;
            kept_y     = '0;
            faults     = 0;
        endfunction

        function void set_register(msfd_pkg::t_reg_idx idx, logic [31:0] value);
            case (idx)
                msfd_pkg::REG_GAIN_ONE:   gain_a = value;
                msfd_pkg::REG_OFFSET_ONE: offset_a = value;
                msfd_pkg::REG_GAIN_TWO:   gain_b = value;
                msfd_pkg::REG_OFFSET_TWO: offset_b = value;
                default: ;
            endcase
        endfunction

        // Q8.24 gain times a 24-bit sample plus the Q16.16 offset, rounded half up to
        // Q16.16 and clamped to the 32-bit range.
        function logic [31:0] calibrate_channel(logic [23:0] raw, logic signed [31:0] gain,
                                                logic signed [31:0] offset);
            longint acc;
            acc = longint'(gain) * longint'($signed(raw)) + longint'(offset) * 256 + 128;
            acc = acc >>> 8;
            if (acc > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (acc < -64'sd2147483648) return 32'h8000_0000;
            return acc[31:0];
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            logic [3:0] crc_lo_pos;
            bit         good, angle;
            t_decoded   r;
            if (start) begin
                frame_addr = b;
                in_frame   = (b >= 8'd1) && (b <= msfd_pkg::ADDR_MAX);
                crc_run    = msfd_pkg::CRC_INIT;
                payload    = '0;
                crc_lo     = '0;
                byte_pos   = '0;
                if (in_frame) begin
                    crc_run  = modbus_crc_byte(crc_run, b);
                    byte_pos = 4'd1;
                end
                return;
            end
            if (!in_frame) return;
            angle      = (frame_addr == msfd_pkg::ADDR_ANGLE);
            crc_lo_pos = angle ? msfd_pkg::ANGLE_CRC_LO : msfd_pkg::ADC_CRC_LO;
            if (byte_pos < crc_lo_pos) begin
                crc_run = modbus_crc_byte(crc_run, b);
                if (byte_pos >= msfd_pkg::PAYLOAD_FIRST) payload = {payload[55:0], b};
                byte_pos++;
            end else if (byte_pos == crc_lo_pos) begin
                crc_lo = b;
                byte_pos++;
            end else begin
                good = (crc_lo == crc_run[7:0]) && (b == crc_run[15:8]);
                r = '0;
                if (angle && good) begin
                    kept_x = payload[63:32];
                    kept_y = payload[31:0];
                end
                if (!angle) begin
                    r.channel_one_value = calibrate_channel(good ? payload[47:24] : 24'h0,
                                                            gain_a, offset_a);
                    r.channel_two_value = calibrate_channel(good ? payload[23:0] : 24'h0,
                                                            gain_b, offset_b);
                end
                r.slave_address = frame_addr[2:0];
                r.crc_ok        = good;
                r.is_angle      = angle;
                r.angle_x_bits  = kept_x;
                r.angle_y_bits  = kept_y;
                pending.push_back(r);
                in_frame = 1'b0;
                byte_pos = '0;
            end
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] seen);
            faults++;
            if (faults <= 10) $display("mismatch on %s: expected %h, got %h", what, want, seen);
        endfunction

        function void check_result(t_decoded got);
            t_decoded want;
            if (pending.size() == 0) begin
                flag("result with no request outstanding", '0, got.slave_address);
                return;
            end
            want = pending.pop_front();
            if (got.slave_address !== want.slave_address)
                flag("slave_address", want.slave_address, got.slave_address);
            if (got.crc_ok !== want.crc_ok) flag("crc_ok", want.crc_ok, got.crc_ok);
            if (got.is_angle !== want.is_angle) flag("is_angle", want.is_angle, got.is_angle);
            if (got.angle_x_bits !== want.angle_x_bits)
                flag("angle_x_bits", want.angle_x_bits, got.angle_x_bits);
            if (got.angle_y_bits !== want.angle_y_bits)
                flag("angle_y_bits", want.angle_y_bits, got.angle_y_bits);
            if (got.channel_one_value !== want.channel_one_value)
                flag("channel_one_value", want.channel_one_value, got.channel_one_value);
            if (got.channel_two_value !== want.channel_two_value)
                flag("channel_two_value", want.channel_two_value, got.channel_two_value);
        endfunction
    endclass

endpackage

>>> verif/tb_modbus_sensor_frame_decoder.sv
// Top-level testbench for modbus_sensor_frame_decoder: drives reply frames and register writes,
// checks every decoded result against the scoreboard in msfd_tb_pkg.
// Depends on msfd_pkg, the msfd_in_if and msfd_out_if interfaces, and msfd_tb_pkg.
module tb_modbus_sensor_frame_decoder;

    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_BYTES  = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    int unsigned send_idle_pct, recv_idle_pct, quiet_cycles;
    bit          moved;
    msfd_tb_pkg::msfd_scoreboard sb;

    msfd_in_if  rx_ch ();
    msfd_out_if res_ch ();

    modbus_sensor_frame_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        moved = 1'b0;
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready) begin
                sb.note_byte(rx_ch.rx_byte, rx_ch.frame_start);
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                sb.check_result('{slave_address: res_ch.slave_address,
                                  crc_ok: res_ch.crc_ok,
                                  is_angle: res_ch.is_angle,
                                  angle_x_bits: res_ch.angle_x_bits,
                                  angle_y_bits: res_ch.angle_y_bits,
                                  channel_one_value: res_ch.channel_one_value,
                                  channel_two_value: res_ch.channel_two_value});
                moved = 1'b1;
            end
            if (psel && penable && pwrite && pready) begin
                sb.set_register(msfd_pkg::t_reg_idx'(paddr[3:2]), pwdata);
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_modbus_sensor_frame_decoder: errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= b;
        rx_ch.frame_start <= start;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic msfd_tb_pkg::t_byte_q random_body(int unsigned n);
        msfd_tb_pkg::t_byte_q q;
        repeat (n) q.push_back(pick_byte());
        return q;
    endfunction

    // Sends the address, the body and a correct CRC, optionally with one flipped bit
    // after the address, and stops after the first keep bytes.
    task automatic send_frame(input logic [7:0] addr, input msfd_tb_pkg::t_byte_q body,
                              input bit corrupt, input int unsigned keep);
        msfd_tb_pkg::t_byte_q q;
        logic [15:0]          crc;
        int unsigned          k, i;
        q = body;
        q.push_front(addr);
        crc = msfd_pkg::CRC_INIT;
        foreach (q[j]) crc = msfd_tb_pkg::modbus_crc_byte(crc, q[j]);
        q.push_back(crc[7:0]);
        q.push_back(crc[15:8]);
        if (corrupt) begin
            k = $urandom_range(1, q.size() - 1);
            q[k] = q[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (i = 0; i < q.size() && i < keep; i++) send_byte(q[i], i == 0);
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned counted, r, n, k;
        logic [7:0]  a;
        counted = 0;
        while (counted < target) begin
            r = $urandom_range(0, 99);
            a = 8'($urandom_range(1, 5));
            n = (a == msfd_pkg::ADDR_ANGLE) ? 10 : 8;
            if (r < 72) begin
                send_frame(a, random_body(n), 1'b0, 99);
                counted += n + 3;
            end else if (r < 82) begin
                send_frame(a, random_body(n), 1'b1, 99);
                counted += n + 3;
            end else if (r < 90) begin
                k = $urandom_range(1, n + 2);
                send_frame(a, random_body(n), 1'b0, k);
                counted += k;
            end else if (r < 95) begin
                a = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(6, 255));
                send_frame(a, random_body($urandom_range(0, 10)), 1'b0, 99);
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(pick_byte(), 1'b0);
            end
        end
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input msfd_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_calibration(input logic [31:0] g1, input logic [31:0] o1,
                                   input logic [31:0] g2, input logic [31:0] o2);
        settle();
        write_reg(msfd_pkg::REG_GAIN_ONE, g1);
        write_reg(msfd_pkg::REG_OFFSET_ONE, o1);
        write_reg(msfd_pkg::REG_GAIN_TWO, g2);
        write_reg(msfd_pkg::REG_OFFSET_TWO, o2);
    endtask

    initial begin
        sb = new();
        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = '0;
        rx_ch.frame_start = 1'b0;
        res_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        quiet_cycles      = 0;
        send_idle_pct     = 11;
        recv_idle_pct     = 83;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sample extremes, then kept angles, a bad CRC on each frame type, an unknown
        // address, a stray byte and a frame abandoned by a new address byte.
        send_frame(8'h02, '{8'h03, 8'h06, 8'h80, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF}, 1'b0, 99);
        send_frame(8'h01, '{8'h03, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                            8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 99);
        send_frame(8'h03, '{8'h04, 8'h06, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 99);
        send_frame(8'h00, '{8'h03}, 1'b0, 99);
        send_byte(8'hA5, 1'b0);
        send_frame(8'h05, random_body(8), 1'b0, 5);
        send_frame(8'h01, '{8'h03, 8'h08, 8'h3F, 8'h80, 8'h00, 8'h00,
                            8'h40, 8'h00, 8'h00, 8'h00}, 1'b1, 99);
        send_frame(8'h04, '{8'h03, 8'h06, 8'h7F, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00}, 1'b0, 99);
        run_random(PHASE_BYTES);

        set_calibration(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_random(PHASE_BYTES);

        send_idle_pct = 83;
        recv_idle_pct = 11;
        set_calibration(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        run_random(PHASE_BYTES);
        set_calibration($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_BYTES);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_calibration(32'h0100_0000, 32'h0000_0000, 32'h0100_0000, 32'hFFFF_0000);
        run_random(PHASE_BYTES);
        set_calibration($urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000, $urandom,
                        $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000, $urandom);
        run_random(PHASE_BYTES);

        settle();
        if (sb.faults == 0) begin
            $display("tb_modbus_sensor_frame_decoder: clean");
        end else begin
            $display("tb_modbus_sensor_frame_decoder: errors");
        end
        $finish;
    end

endmodule
